FILE: rtl/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg: shared definitions for the max-heap priority queue
// Field widths, result status codes, the datapath command set and the
// status bundle returned from the datapath to the controller.
// ----------------------------------------------------------------------------
package mhpq_pkg;

   localparam int KeyW         = 32;
   localparam int StatusW      = 2;
   localparam int CountAfterW  = 8;
   localparam int CapacityDflt = 128;

   localparam logic [StatusW-1:0] ST_OK    = 2'd0;
   localparam logic [StatusW-1:0] ST_EMPTY = 2'd1;
   localparam logic [StatusW-1:0] ST_FULL  = 2'd2;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   // One command per cycle from the controller to the datapath.
   typedef enum logic [3:0] {
      DP_NOP,
      DP_LATCH,
      DP_FULL,
      DP_EMPTY,
      DP_START_INS,
      DP_READ_ENDS,
      DP_LOAD_ROOT,
      DP_READ_PARENT,
      DP_MOVE_PARENT,
      DP_READ_CHILDREN,
      DP_MOVE_CHILD,
      DP_PLACE,
      DP_LOAD_RSP
   } dp_op_type;

   typedef struct packed {
      logic is_remove;
      logic full;
      logic empty;
      logic at_root;
      logic key_gt_parent;
      logic leaf;
      logic child_wins;
   } dp_status_type;

endpackage

FILE: rtl/mhpq_intf.sv
// ----------------------------------------------------------------------------
// mhpq_req_if / mhpq_rsp_if: valid/ready channels of the priority queue
// The request channel carries an operation and a key; the response channel
// carries the removed key, a status code and the count after the operation.
// ----------------------------------------------------------------------------
interface mhpq_req_if
   import mhpq_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic                     cmd;
   logic signed [KeyW-1:0]   key;

   modport source (output valid, output cmd, output key, input ready);
   modport sink   (input valid, input cmd, input key, output ready);
endinterface

interface mhpq_rsp_if
   import mhpq_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic signed [KeyW-1:0]   removed_key;
   logic [StatusW-1:0]       status;
   logic [CountAfterW-1:0]   count_after;

   modport source (output valid, output removed_key, output status, output count_after,
                   input ready);
   modport sink   (input valid, input removed_key, input status, input count_after,
                   output ready);
endinterface

FILE: rtl/mhpq_dp.sv
// ----------------------------------------------------------------------------
// mhpq_dp: heap datapath
// Holds the key store, the key count, the moving key and its position, and
// the response registers. Sifts use a hole: the moving key stays in a
// register and is written once, at its final position.
// ----------------------------------------------------------------------------
module mhpq_dp
   import mhpq_pkg::*;
#(
   parameter int CAPACITY = CapacityDflt
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dp_op_type                op,
   output dp_status_type            stat,
   input  logic                     req_cmd,
   input  logic signed [KeyW-1:0]   req_key,
   output logic signed [KeyW-1:0]   rsp_removed_key,
   output logic [StatusW-1:0]       rsp_status,
   output logic [CountAfterW-1:0]   rsp_count_after
);

   localparam int AW  = $clog2(CAPACITY);
   localparam int PW  = $clog2(CAPACITY + 1);
   localparam int CHW = PW + 1;

   logic signed [KeyW-1:0] mem [CAPACITY];

   logic signed [KeyW-1:0] rd0_ff, rd1_ff;
   logic                   cmd_ff;
   logic signed [KeyW-1:0] key_ff;
   logic [PW-1:0]          pos_ff;
   logic [PW-1:0]          count_ff;
   logic signed [KeyW-1:0] res_key_ff;
   logic [StatusW-1:0]     res_status_ff;
   logic signed [KeyW-1:0] out_key_ff;
   logic [StatusW-1:0]     out_status_ff;
   logic [CountAfterW-1:0] out_count_ff;

   logic [AW-1:0]          rd0_addr, rd1_addr, wr_addr;
   logic [CHW-1:0]         left_pos, right_pos, child_pos;
   logic [PW-1:0]          parent_pos;
   logic                   pick_right;
   logic signed [KeyW-1:0] child_val;

   assign left_pos   = {pos_ff, 1'b0};
   assign right_pos  = {pos_ff, 1'b1};
   assign parent_pos = pos_ff >> 1;
   assign wr_addr    = AW'(pos_ff - 1'b1);

   // The right child counts only when it exists and is strictly larger.
   assign pick_right = (right_pos <= {1'b0, count_ff}) && (rd1_ff > rd0_ff);
   assign child_val  = pick_right ? rd1_ff : rd0_ff;
   assign child_pos  = pick_right ? right_pos : left_pos;

   always_comb begin
      rd0_addr = AW'(left_pos - 1'b1);
      rd1_addr = AW'(right_pos - 1'b1);
      case (op)
         DP_READ_ENDS: begin
            rd0_addr = '0;
            rd1_addr = AW'(count_ff - 1'b1);
         end
         DP_READ_PARENT: begin
            rd0_addr = AW'(parent_pos - 1'b1);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      stat.is_remove     = (cmd_ff == CMD_REMOVE);
      stat.full          = (count_ff >= PW'(CAPACITY));
      stat.empty         = (count_ff == '0);
      stat.at_root       = (pos_ff == PW'(1));
      stat.key_gt_parent = (key_ff > rd0_ff);
      stat.leaf          = (left_pos > {1'b0, count_ff});
      stat.child_wins    = (child_val > key_ff);
   end

   // Key store: two registered read ports, one write port.
   always_ff @(posedge clock) begin
      rd0_ff <= mem[rd0_addr];
      rd1_ff <= mem[rd1_addr];
      case (op)
         DP_MOVE_PARENT: mem[wr_addr] <= rd0_ff;
         DP_MOVE_CHILD:  mem[wr_addr] <= child_val;
         DP_PLACE:       mem[wr_addr] <= key_ff;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         case (op)
            DP_START_INS: count_ff <= PW'(count_ff + 1'b1);
            DP_LOAD_ROOT: count_ff <= PW'(count_ff - 1'b1);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (op)
         DP_LATCH: begin
            cmd_ff <= req_cmd;
            key_ff <= req_key;
         end
         DP_FULL: begin
            res_key_ff    <= '0;
            res_status_ff <= ST_FULL;
         end
         DP_EMPTY: begin
            res_key_ff    <= '0;
            res_status_ff <= ST_EMPTY;
         end
         DP_START_INS: begin
            pos_ff        <= PW'(count_ff + 1'b1);
            res_key_ff    <= '0;
            res_status_ff <= ST_OK;
         end
         DP_LOAD_ROOT: begin
            key_ff        <= rd1_ff;
            pos_ff        <= PW'(1);
            res_key_ff    <= rd0_ff;
            res_status_ff <= ST_OK;
         end
         DP_MOVE_PARENT: pos_ff <= parent_pos;
         DP_MOVE_CHILD:  pos_ff <= PW'(child_pos);
         DP_LOAD_RSP: begin
            out_key_ff    <= res_key_ff;
            out_status_ff <= res_status_ff;
            out_count_ff  <= CountAfterW'(count_ff);
         end
         default: begin
         end
      endcase
   end

   assign rsp_removed_key = out_key_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_count_after = out_count_ff;

endmodule

FILE: rtl/mhpq_ctrl.sv
// ----------------------------------------------------------------------------
// mhpq_ctrl: heap controller
// Sequences insert and remove operations over the datapath one step per cycle
// but holds for a busy output register; owns request ready and response valid.
// ----------------------------------------------------------------------------
module mhpq_ctrl
   import mhpq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type stat,
   output dp_op_type     op
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_INS_STEP,
      S_INS_CMP,
      S_RM_LOAD,
      S_SD_STEP,
      S_SD_CMP,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      op           = DP_NOP;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op       = DP_LATCH;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (!stat.is_remove) begin
               if (stat.full) begin
                  op       = DP_FULL;
                  state_in = S_FINISH;
               end else begin
                  op       = DP_START_INS;
                  state_in = S_INS_STEP;
               end
            end else if (stat.empty) begin
               op       = DP_EMPTY;
               state_in = S_FINISH;
            end else begin
               op       = DP_READ_ENDS;
               state_in = S_RM_LOAD;
            end
         end
         S_INS_STEP: begin
            if (stat.at_root) begin
               op       = DP_PLACE;
               state_in = S_FINISH;
            end else begin
               op       = DP_READ_PARENT;
               state_in = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            if (stat.key_gt_parent) begin
               op       = DP_MOVE_PARENT;
               state_in = S_INS_STEP;
            end else begin
               op       = DP_PLACE;
               state_in = S_FINISH;
            end
         end
         S_RM_LOAD: begin
            op       = DP_LOAD_ROOT;
            state_in = S_SD_STEP;
         end
         S_SD_STEP: begin
            if (stat.leaf) begin
               op       = DP_PLACE;
               state_in = S_FINISH;
            end else begin
               op       = DP_READ_CHILDREN;
               state_in = S_SD_CMP;
            end
         end
         S_SD_CMP: begin
            if (stat.child_wins) begin
               op       = DP_MOVE_CHILD;
               state_in = S_SD_STEP;
            end else begin
               op       = DP_PLACE;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               op           = DP_LOAD_RSP;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/max_heap_priority_queue_top.sv
// A full-heap insert or an empty remove goes straight to the response; other
// operations add a read and a compare for each level the key moves.
// Throughput: one request at a time; the next request beat is taken once the
// current result is in the output register.
// Reset: synchronous, active high; clears the key count and the handshake state.
// ----------------------------------------------------------------------------
// max_heap_priority_queue_top: binary max-heap priority queue
// Each request beat either inserts a signed key or removes the maximum; each
// produces exactly one response beat with the removed key, a status code and
// the number of keys held afterwards.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_top
   import mhpq_pkg::*;
#(
   parameter int CAPACITY = CapacityDflt
) (
   input  logic        clock,
   input  logic        reset,
   mhpq_req_if.sink    req_ch,
   mhpq_rsp_if.source  rsp_ch
);

   // The controller issues one datapath command per cycle and reacts to the
   // comparison results that come back in the status bundle.
   dp_op_type     dp_op;
   dp_status_type dp_stat;

   // The controller owns the handshake: the request side is ready only while
   // no operation is in flight, and the response valid is a register that is
   // loaded when a finished result finds the output register free. A waiting
   // response does not hold off the next request beat.
   mhpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (dp_stat),
      .op        (dp_op)
   );

   // The datapath holds the key store (one write and two registered read
   // ports), the key count and the response payload registers. Sift-up reads
   // one parent per level; sift-down reads both children together.
   mhpq_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .op              (dp_op),
      .stat            (dp_stat),
      .req_cmd         (req_ch.cmd),
      .req_key         (req_ch.key),
      .rsp_removed_key (rsp_ch.removed_key),
      .rsp_status      (rsp_ch.status),
      .rsp_count_after (rsp_ch.count_after)
   );

endmodule
